// File: hw/rtl/gcab_pkg.sv
// shared types and constants for the glyph coverage alpha blend unit
// configuration layout, register indexes and pipeline stage payload
// no dependencies
package gcab_pkg;

    // apb address width: seven 32-bit registers at 4*i
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register indexes (byte address bits 4:2)
    localparam logic [2:0] REG_ORIGIN_X         = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y         = 3'd1;
    localparam logic [2:0] REG_GLYPH_WIDTH      = 3'd2;
    localparam logic [2:0] REG_GLYPH_HEIGHT     = 3'd3;
    localparam logic [2:0] REG_FG_COLOR         = 3'd4;
    localparam logic [2:0] REG_BLEND_BG_COLOR   = 3'd5;
    localparam logic [2:0] REG_TRANSPARENT_MODE = 3'd6;

    // reset values
    localparam logic [7:0]  GLYPH_DIM_RESET  = 8'd1;
    localparam logic [23:0] FG_COLOR_RESET   = 24'hFF_FFFF;
    localparam logic [7:0]  CHANNEL_MAX      = 8'd255;

    // configuration seen by the datapath
    typedef struct packed {
        logic signed [11:0] origin_x;
        logic signed [11:0] origin_y;
        logic [7:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic [23:0]        fg_color;
        logic [23:0]        blend_bg_color;
        logic               transparent_mode;
    } cfg_t;

    // item held in the input stage
    typedef struct packed {
        logic [7:0] coverage;
        logic [7:0] column;
        logic [7:0] row;
        logic       last;
    } stage_t;

endpackage

// File: hw/rtl/gcab_cov_if.sv
// coverage byte channel: valid/ready handshake with 8-bit payload
// no dependencies
interface gcab_cov_if;
    logic       valid;
    logic       ready;
    logic [7:0] coverage;

    modport source (output valid, output coverage, input ready);
    modport sink   (input valid, input coverage, output ready);
endinterface

// File: hw/rtl/gcab_pix_if.sv
// pixel result channel: valid/ready handshake with coordinate, color and flags
// no dependencies
interface gcab_pix_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] pixel_x;
    logic signed [12:0] pixel_y;
    logic [23:0]        pixel_color;
    logic               write_enable;
    logic               last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                    output write_enable, output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                    input write_enable, input last_pixel, output ready);
endinterface

// File: hw/rtl/gcab_regs.sv
// apb configuration registers for the glyph blend unit
// depends on gcab_pkg
module gcab_regs
    import gcab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_ORIGIN_X:         cfg_next.origin_x         = pwdata[11:0];
                REG_ORIGIN_Y:         cfg_next.origin_y         = pwdata[11:0];
                REG_GLYPH_WIDTH:      cfg_next.glyph_width      = pwdata[7:0];
                REG_GLYPH_HEIGHT:     cfg_next.glyph_height     = pwdata[7:0];
                REG_FG_COLOR:         cfg_next.fg_color         = pwdata[23:0];
                REG_BLEND_BG_COLOR:   cfg_next.blend_bg_color   = pwdata[23:0];
                REG_TRANSPARENT_MODE: cfg_next.transparent_mode = pwdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x         <= '0;
            cfg_reg.origin_y         <= '0;
            cfg_reg.glyph_width      <= GLYPH_DIM_RESET;
            cfg_reg.glyph_height     <= GLYPH_DIM_RESET;
            cfg_reg.fg_color         <= FG_COLOR_RESET;
            cfg_reg.blend_bg_color   <= '0;
            cfg_reg.transparent_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_ORIGIN_X:         prdata = {20'd0, cfg_reg.origin_x};
            REG_ORIGIN_Y:         prdata = {20'd0, cfg_reg.origin_y};
            REG_GLYPH_WIDTH:      prdata = {24'd0, cfg_reg.glyph_width};
            REG_GLYPH_HEIGHT:     prdata = {24'd0, cfg_reg.glyph_height};
            REG_FG_COLOR:         prdata = {8'd0, cfg_reg.fg_color};
            REG_BLEND_BG_COLOR:   prdata = {8'd0, cfg_reg.blend_bg_color};
            REG_TRANSPARENT_MODE: prdata = {31'd0, cfg_reg.transparent_mode};
            default:              prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/gcab_walker.sv
// input stage: takes coverage bytes, steps column/row counters, flags glyph end
// depends on gcab_pkg and gcab_cov_if
module gcab_walker
    import gcab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    gcab_cov_if.sink  cov,
    input  logic      stage_ready,
    output logic      stage_valid,
    output stage_t    stage_data
);

    logic [7:0] column_reg;
    logic [7:0] column_next;
    logic [7:0] row_reg;
    logic [7:0] row_next;
    logic       valid_reg;
    logic       valid_next;
    stage_t     data_reg;
    logic       take;
    logic [7:0] width_eff;
    logic [7:0] height_eff;
    logic       row_end;
    logic       glyph_end;

    assign cov.ready   = !valid_reg || stage_ready;
    assign take        = cov.valid && cov.ready;
    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

    // a zero width or height acts as one
    assign width_eff  = (cfg.glyph_width == 8'd0) ? 8'd1 : cfg.glyph_width;
    assign height_eff = (cfg.glyph_height == 8'd0) ? 8'd1 : cfg.glyph_height;

    // end of row / glyph, also when a limit shrank below the counter
    assign row_end   = ({1'b0, column_reg} + 9'd1) >= {1'b0, width_eff};
    assign glyph_end = row_end && (({1'b0, row_reg} + 9'd1) >= {1'b0, height_eff});

    // counter advance on each transfer
    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (take)
        begin
            if (glyph_end)
            begin
                column_next = '0;
                row_next    = '0;
            end
            else if (row_end)
            begin
                column_next = '0;
                row_next    = row_reg + 8'd1;
            end
            else
            begin
                column_next = column_reg + 8'd1;
            end
        end
    end

    // stage valid flag
    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (stage_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            valid_reg  <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg.coverage <= cov.coverage;
            data_reg.column   <= column_reg;
            data_reg.row      <= row_reg;
            data_reg.last     <= glyph_end;
        end
    end

endmodule

// File: hw/rtl/gcab_blend.sv
// result stage: pixel coordinates, per-channel alpha blend and output register
// depends on gcab_pkg and gcab_pix_if
module gcab_blend
    import gcab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        stage_valid,
    input  stage_t      stage_data,
    output logic        stage_ready,
    gcab_pix_if.source  pix
);

    logic               valid_reg;
    logic               valid_next;
    logic signed [12:0] px_reg;
    logic signed [12:0] py_reg;
    logic [23:0]        color_reg;
    logic               we_reg;
    logic               last_reg;
    logic signed [12:0] px_next;
    logic signed [12:0] py_next;
    logic [23:0]        color_next;
    logic               we_next;
    logic [23:0]        blended;
    logic [7:0]         inv_cov;
    logic               take;

    assign stage_ready = !valid_reg || pix.ready;
    assign take        = stage_valid && stage_ready;

    // origin plus counter, sign-extended to 13 bits
    assign px_next = {cfg.origin_x[11], cfg.origin_x} + {5'd0, stage_data.column};
    assign py_next = {cfg.origin_y[11], cfg.origin_y} + {5'd0, stage_data.row};

    assign inv_cov = CHANNEL_MAX - stage_data.coverage;

    // per-channel blend; the sum never exceeds 255*255 so 16 bits hold it
    always_comb
    begin
        logic [15:0] fg_prod;
        logic [15:0] bg_prod;
        logic [15:0] sum;
        blended = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            fg_prod = cfg.fg_color[ch*8 +: 8] * stage_data.coverage;
            bg_prod = cfg.blend_bg_color[ch*8 +: 8] * inv_cov;
            sum     = fg_prod + bg_prod;
            blended[ch*8 +: 8] = sum[15:8];
        end
    end

    // zero coverage: background fill, or no write in transparent mode
    always_comb
    begin
        if (stage_data.coverage != 8'd0)
        begin
            color_next = blended;
            we_next    = 1'b1;
        end
        else if (cfg.transparent_mode)
        begin
            color_next = '0;
            we_next    = 1'b0;
        end
        else
        begin
            color_next = cfg.blend_bg_color;
            we_next    = 1'b1;
        end
    end

    // output valid flag
    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (pix.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            color_reg <= color_next;
            we_reg    <= we_next;
            last_reg  <= stage_data.last;
        end
    end

    assign pix.valid        = valid_reg;
    assign pix.pixel_x      = px_reg;
    assign pix.pixel_y      = py_reg;
    assign pix.pixel_color  = color_reg;
    assign pix.write_enable = we_reg;
    assign pix.last_pixel   = last_reg;

endmodule

// File: hw/rtl/glyph_coverage_alpha_blend_unit.sv
// glyph coverage alpha blend unit, top level
// each byte is registered in the input stage, then in the result stage, before output
// throughput: one coverage byte per cycle while pix.ready holds, set by the two-register
// pipeline (input stage with counters, result stage with blend multipliers)
// reset clears counters, valid flags and restores register defaults
// depends on gcab_pkg, gcab_cov_if, gcab_pix_if, gcab_regs, gcab_walker, gcab_blend
module glyph_coverage_alpha_blend_unit
    import gcab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    gcab_cov_if.sink              cov,
    gcab_pix_if.source            pix
);

    cfg_t   cfg;
    logic   stage_valid;
    logic   stage_ready;
    stage_t stage_data;

    // configuration registers
    gcab_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input stage and glyph walk counters
    gcab_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cov         (cov),
        .stage_ready (stage_ready),
        .stage_valid (stage_valid),
        .stage_data  (stage_data)
    );

    // blend and result register
    gcab_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage_data  (stage_data),
        .stage_ready (stage_ready),
        .pix         (pix)
    );

`ifndef SYNTHESIS
    // a stalled input stage keeps its item
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid && !stage_ready |=> stage_valid && $stable(stage_data))
        else $error("input stage item lost while stalled");

    // every input transfer lands in the input stage
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        cov.valid && cov.ready |=> stage_valid)
        else $error("input transfer not captured");

    // a suppressed write only comes from transparent mode and carries no color
    a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && !pix.write_enable |-> pix.pixel_color == '0 && cfg.transparent_mode)
        else $error("unexpected suppressed pixel write");
`endif

endmodule
